>>> rtl/hap_pkg.sv
// hap_pkg: shared widths, constants, cordic angle table and the geometry bundle
// for the holonomic acceleration penalty pipeline; no dependencies
package hap_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 34;
    localparam int CW           = 32;
    localparam int DISPW        = 36;
    localparam int DIV1_NW      = 52;
    localparam int DIV2_NW      = 63;
    localparam int VW           = 46;
    localparam int TW           = 24;

    localparam logic signed [CW-1:0] INV_GAIN_Q29 = 32'sd326016437;
    localparam logic signed [ZW-1:0] PI_Q29       = 34'sd1686629713;
    localparam logic signed [ZW-1:0] HALF_PI_Q29  = 34'sd843314857;
    localparam logic signed [16:0]   PI_Q13       = 17'sd25736;
    localparam logic signed [16:0]   TWO_PI_Q13   = 17'sd51472;
    localparam logic signed [52:0]   VEL_SAT      = 53'sd17592186044416;
    localparam logic [39:0]          EXCESS_CAP   = 40'hFF_FFFF_FFFF;

    localparam logic [2:0] REG_LIM_X   = 3'd0;
    localparam logic [2:0] REG_LIM_Y   = 3'd1;
    localparam logic [2:0] REG_LIM_R   = 3'd2;
    localparam logic [2:0] REG_MARGIN  = 3'd3;
    localparam logic [2:0] REG_RW_X    = 3'd4;
    localparam logic [2:0] REG_RW_Y    = 3'd5;
    localparam logic [2:0] REG_RW_R    = 3'd6;

    typedef struct packed {
        logic signed [32:0] d1x;
        logic signed [32:0] d1y;
        logic signed [32:0] d2x;
        logic signed [32:0] d2y;
        logic [TW-1:0]      t1;
        logic [TW-1:0]      t2;
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic               fault;
    } t_geo;

    function automatic logic signed [ZW-1:0] atan_q29(input int i);
        case (i)
            0:       atan_q29 = 34'sd421657428;
            1:       atan_q29 = 34'sd248918915;
            2:       atan_q29 = 34'sd131521918;
            3:       atan_q29 = 34'sd66762579;
            4:       atan_q29 = 34'sd33510843;
            5:       atan_q29 = 34'sd16771758;
            6:       atan_q29 = 34'sd8387925;
            7:       atan_q29 = 34'sd4194219;
            8:       atan_q29 = 34'sd2097141;
            9:       atan_q29 = 34'sd1048575;
            default: atan_q29 = 34'sd1 <<< (29 - i);
        endcase
    endfunction

endpackage

>>> rtl/holonomic_accel_penalty_top.sv
// holonomic_accel_penalty_top: pose triple to weighted acceleration penalties
// depends on hap_pkg, hap_cordic, hap_div and hap_pen
//
//  port group   dir  width  beat contents
//  s_axis       in   288    pose a, pose b, pose c, step_ab, step_bc
//  m_axis       out  96+1   penalty x, y, turn; tuser step_fault
//  cfg          in   3+32   register index and write data
//
// one beat accepted per cycle while no output beat is held; stages: pre stage,
// 24 cordic steps, product/sum/magnitude, 52-bit velocity divider, 3 stages,
// 63-bit acceleration divider, 3 penalty stages
// i_rst_n is synchronous; it clears the valid bits and loads register defaults
// a held output beat stalls the whole pipeline, nothing is dropped
module holonomic_accel_penalty_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // ax, ay, ha, bx, by, hb, cx, cy, hc, step_ab, step_bc
    input  logic [287:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // penalty_x, penalty_y, penalty_turn
    output logic [95:0]  o_m_axis_tdata,
    // step_fault
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import hap_pkg::*;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // configuration
    logic [2:0][31:0] r_limit;
    logic [15:0]      r_margin;
    logic [2:0][23:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= {3{32'd32768}};
            r_margin <= 16'd6554;
            r_weight <= {3{24'd65536}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LIM_X:  r_limit[0]  <= i_cfg_data;
                REG_LIM_Y:  r_limit[1]  <= i_cfg_data;
                REG_LIM_R:  r_limit[2]  <= i_cfg_data;
                REG_MARGIN: r_margin    <= i_cfg_data[15:0];
                REG_RW_X:   r_weight[0] <= i_cfg_data[23:0];
                REG_RW_Y:   r_weight[1] <= i_cfg_data[23:0];
                REG_RW_R:   r_weight[2] <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // pre stage
    logic signed [31:0] ax, ay, bx, by, cx, cy;
    logic signed [15:0] ha, hb, hc;
    logic [TW-1:0]      t1, t2;
    logic signed [ZW-1:0] n_za, n_zb, r_za, r_zb;
    logic n_fa, n_fb, r_fa, r_fb, r_s0_vld;
    logic signed [16:0] dw1, dw2;
    t_geo n_geo, r_geo;

    assign ax = i_s_axis_tdata[31:0];
    assign ay = i_s_axis_tdata[63:32];
    assign ha = i_s_axis_tdata[79:64];
    assign bx = i_s_axis_tdata[111:80];
    assign by = i_s_axis_tdata[143:112];
    assign hb = i_s_axis_tdata[159:144];
    assign cx = i_s_axis_tdata[191:160];
    assign cy = i_s_axis_tdata[223:192];
    assign hc = i_s_axis_tdata[239:224];
    assign t1 = i_s_axis_tdata[263:240];
    assign t2 = i_s_axis_tdata[287:264];

    function automatic logic signed [16:0] wrap_q13(input logic signed [16:0] d);
        logic signed [16:0] r;
        r = d;
        if (d >= PI_Q13) begin
            r = d - TWO_PI_Q13;
        end else if (d < -PI_Q13) begin
            r = d + TWO_PI_Q13;
        end
        return r;
    endfunction

    always_comb begin
        n_za = {{2{ha[15]}}, ha, 16'b0};
        n_fa = 1'b0;
        if (n_za > HALF_PI_Q29) begin
            n_za = n_za - PI_Q29;
            n_fa = 1'b1;
        end else if (n_za < -HALF_PI_Q29) begin
            n_za = n_za + PI_Q29;
            n_fa = 1'b1;
        end
        n_zb = {{2{hb[15]}}, hb, 16'b0};
        n_fb = 1'b0;
        if (n_zb > HALF_PI_Q29) begin
            n_zb = n_zb - PI_Q29;
            n_fb = 1'b1;
        end else if (n_zb < -HALF_PI_Q29) begin
            n_zb = n_zb + PI_Q29;
            n_fb = 1'b1;
        end
        dw1 = wrap_q13({hb[15], hb} - {ha[15], ha});
        dw2 = wrap_q13({hc[15], hc} - {hb[15], hb});
        n_geo.d1x   = {bx[31], bx} - {ax[31], ax};
        n_geo.d1y   = {by[31], by} - {ay[31], ay};
        n_geo.d2x   = {cx[31], cx} - {bx[31], bx};
        n_geo.d2y   = {cy[31], cy} - {by[31], by};
        n_geo.t1    = t1;
        n_geo.t2    = t2;
        n_geo.w1    = dw1[15:0];
        n_geo.w2    = dw2[15:0];
        n_geo.fault = (t1 == '0) || (t2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_s_axis_tvalid;
        end
        if (en) begin
            r_za  <= n_za;
            r_zb  <= n_zb;
            r_fa  <= n_fa;
            r_fb  <= n_fb;
            r_geo <= n_geo;
        end
    end

    // sine and cosine
    logic                 cor_vld, cor_fa, cor_fb;
    logic signed [CW-1:0] c1, s1, c2, s2;
    t_geo                 cor_geo;
    t_geo                 cor_geo_in;

    assign cor_geo_in = r_geo;

    hap_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s0_vld),
        .i_za     (r_za),
        .i_zb     (r_zb),
        .i_flip_a (r_fa),
        .i_flip_b (r_fb),
        .i_geo    (cor_geo_in),
        .o_valid  (cor_vld),
        .o_ca     (c1),
        .o_sa     (s1),
        .o_cb     (c2),
        .o_sb     (s2),
        .o_flip_a (cor_fa),
        .o_flip_b (cor_fb),
        .o_geo    (cor_geo)
    );

    // products, sums, magnitudes
    logic signed [64:0] r_p [8];
    logic               r_m1_vld, r_m1_fa, r_m1_fb;
    t_geo               r_m1_geo;
    logic signed [65:0] sum [4];
    logic signed [DISPW-1:0] r_disp [4];
    logic               r_m2_vld;
    t_geo               r_m2_geo;
    logic [5:0][DIV1_NW-1:0] r_num1;
    logic [5:0][TW-1:0]      r_den1;
    logic [5:0]              r_neg1;
    logic                    r_m3_vld, r_m3_flt;
    logic [DISPW-1:0]        dmag [4];
    logic [15:0]             wmag [2];

    always_comb begin
        sum[0] = {r_p[0][64], r_p[0]} + {r_p[1][64], r_p[1]};
        sum[1] = {r_p[2][64], r_p[2]} - {r_p[3][64], r_p[3]};
        sum[2] = {r_p[4][64], r_p[4]} + {r_p[5][64], r_p[5]};
        sum[3] = {r_p[6][64], r_p[6]} - {r_p[7][64], r_p[7]};
        if (r_m1_fa) begin
            sum[0] = -sum[0];
            sum[1] = -sum[1];
        end
        if (r_m1_fb) begin
            sum[2] = -sum[2];
            sum[3] = -sum[3];
        end
        for (int l = 0; l < 4; l++) begin
            dmag[l] = r_disp[l][DISPW-1] ? DISPW'(-r_disp[l]) : DISPW'(r_disp[l]);
        end
        wmag[0] = r_m2_geo.w1[15] ? 16'(-r_m2_geo.w1) : 16'(r_m2_geo.w1);
        wmag[1] = r_m2_geo.w2[15] ? 16'(-r_m2_geo.w2) : 16'(r_m2_geo.w2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= cor_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
        if (en) begin
            r_p[0]   <= c1 * cor_geo.d1x;
            r_p[1]   <= s1 * cor_geo.d1y;
            r_p[2]   <= c1 * cor_geo.d1y;
            r_p[3]   <= s1 * cor_geo.d1x;
            r_p[4]   <= c2 * cor_geo.d2x;
            r_p[5]   <= s2 * cor_geo.d2y;
            r_p[6]   <= c2 * cor_geo.d2y;
            r_p[7]   <= s2 * cor_geo.d2x;
            r_m1_fa  <= cor_fa;
            r_m1_fb  <= cor_fb;
            r_m1_geo <= cor_geo;
            for (int l = 0; l < 4; l++) begin
                r_disp[l] <= sum[l][29+DISPW-1:29];
            end
            r_m2_geo <= r_m1_geo;
            for (int l = 0; l < 4; l++) begin
                r_num1[l] <= {dmag[l], 16'b0};
                r_neg1[l] <= r_disp[l][DISPW-1];
            end
            r_num1[4] <= DIV1_NW'({wmag[0], 19'b0});
            r_num1[5] <= DIV1_NW'({wmag[1], 19'b0});
            r_neg1[4] <= r_m2_geo.w1[15];
            r_neg1[5] <= r_m2_geo.w2[15];
            r_den1    <= {r_m2_geo.t2, r_m2_geo.t1, r_m2_geo.t2, r_m2_geo.t2,
                          r_m2_geo.t1, r_m2_geo.t1};
            r_m3_flt  <= r_m2_geo.fault;
        end
    end

    // velocities: lanes v1x, v1y, v2x, v2y, o1, o2
    localparam int SW1 = 6 + 2 * TW + 1;
    logic                    d1_vld;
    logic [5:0][DIV1_NW-1:0] q1;
    logic [SW1-1:0]          d1_side;

    hap_div #(
        .LANES (6),
        .NW    (DIV1_NW),
        .DW    (TW),
        .SW    (SW1)
    ) u_div_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_vld),
        .i_num   (r_num1),
        .i_den   (r_den1),
        .i_side  ({r_m3_flt, r_den1[2], r_den1[0], r_neg1}),
        .o_valid (d1_vld),
        .o_quo   (q1),
        .o_side  (d1_side)
    );

    logic signed [52:0]   sv [6];
    logic signed [VW-1:0] r_v [6];
    logic [TW:0]          r_tsum, r_w_tsum, r_x_tsum;
    logic                 r_v_vld, r_v_flt, r_w_vld, r_w_flt, r_x_vld, r_x_flt;
    logic signed [VW:0]   r_w [3];
    logic [2:0][DIV2_NW-1:0] r_num2;
    logic [VW:0]          amag [3];

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            sv[l] = d1_side[l] ? -$signed({1'b0, q1[l]}) : $signed({1'b0, q1[l]});
            if (l < 4) begin
                if (sv[l] > VEL_SAT) begin
                    sv[l] = VEL_SAT;
                end else if (sv[l] < -VEL_SAT) begin
                    sv[l] = -VEL_SAT;
                end
            end
        end
        for (int l = 0; l < 3; l++) begin
            amag[l] = r_w[l][VW] ? (VW+1)'(-r_w[l]) : (VW+1)'(r_w[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
            r_w_vld <= 1'b0;
            r_x_vld <= 1'b0;
        end else if (en) begin
            r_v_vld <= d1_vld;
            r_w_vld <= r_v_vld;
            r_x_vld <= r_w_vld;
        end
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                r_v[l] <= sv[l][VW-1:0];
            end
            r_tsum   <= {1'b0, d1_side[6 +: TW]} + {1'b0, d1_side[6+TW +: TW]};
            r_v_flt  <= d1_side[SW1-1];
            r_w[0]   <= {r_v[2][VW-1], r_v[2]} - {r_v[0][VW-1], r_v[0]};
            r_w[1]   <= {r_v[3][VW-1], r_v[3]} - {r_v[1][VW-1], r_v[1]};
            r_w[2]   <= {r_v[5][VW-1], r_v[5]} - {r_v[4][VW-1], r_v[4]};
            r_w_tsum <= r_tsum;
            r_w_flt  <= r_v_flt;
            for (int l = 0; l < 3; l++) begin
                r_num2[l] <= {amag[l][VW-1:0], 17'b0};
            end
            r_x_tsum <= r_w_tsum;
            r_x_flt  <= r_w_flt;
        end
    end

    // accelerations
    logic                    d2_vld, d2_flt;
    logic [2:0][DIV2_NW-1:0] q2;

    hap_div #(
        .LANES (3),
        .NW    (DIV2_NW),
        .DW    (TW + 1),
        .SW    (1)
    ) u_div_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_x_vld),
        .i_num   (r_num2),
        .i_den   ({3{r_x_tsum}}),
        .i_side  (r_x_flt),
        .o_valid (d2_vld),
        .o_quo   (q2),
        .o_side  (d2_flt)
    );

    logic [2:0][31:0] pen;

    hap_pen u_pen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d2_vld),
        .i_fault  (d2_flt),
        .i_mag    (q2),
        .i_limit  (r_limit),
        .i_margin (r_margin),
        .i_weight (r_weight),
        .o_valid  (o_m_axis_tvalid),
        .o_fault  (o_m_axis_tuser),
        .o_pen    (pen)
    );

    assign o_m_axis_tdata = pen;

`ifndef NO_ASSERTIONS
    a_fault_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '1)
        else $error("fault beat without saturated penalties");
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");
`endif

endmodule

>>> rtl/hap_cordic.sv
// hap_cordic: two-lane unrolled rotation cordic, one register stage per step
// depends on hap_pkg for widths, gain, angle table and the geometry bundle
module hap_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [hap_pkg::ZW-1:0] i_za,
    input  logic signed [hap_pkg::ZW-1:0] i_zb,
    input  logic                          i_flip_a,
    input  logic                          i_flip_b,
    input  hap_pkg::t_geo                 i_geo,
    output logic                          o_valid,
    output logic signed [hap_pkg::CW-1:0] o_ca,
    output logic signed [hap_pkg::CW-1:0] o_sa,
    output logic signed [hap_pkg::CW-1:0] o_cb,
    output logic signed [hap_pkg::CW-1:0] o_sb,
    output logic                          o_flip_a,
    output logic                          o_flip_b,
    output hap_pkg::t_geo                 o_geo
);
    import hap_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [CW-1:0] r_xa [N];
    logic signed [CW-1:0] r_ya [N];
    logic signed [ZW-1:0] r_za [N];
    logic signed [CW-1:0] r_xb [N];
    logic signed [CW-1:0] r_yb [N];
    logic signed [ZW-1:0] r_zb [N];
    logic                 r_fa [N];
    logic                 r_fb [N];
    t_geo                 r_geo [N];
    logic                 r_vld [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [CW-1:0] xa, ya, xb, yb;
        logic signed [ZW-1:0] za, zb;
        logic                 fa, fb, v;
        t_geo                 g;

        if (k == 0) begin : g_first
            assign xa = INV_GAIN_Q29;
            assign ya = '0;
            assign za = i_za;
            assign xb = INV_GAIN_Q29;
            assign yb = '0;
            assign zb = i_zb;
            assign fa = i_flip_a;
            assign fb = i_flip_b;
            assign g  = i_geo;
            assign v  = i_valid;
        end else begin : g_next
            assign xa = r_xa[k-1];
            assign ya = r_ya[k-1];
            assign za = r_za[k-1];
            assign xb = r_xb[k-1];
            assign yb = r_yb[k-1];
            assign zb = r_zb[k-1];
            assign fa = r_fa[k-1];
            assign fb = r_fb[k-1];
            assign g  = r_geo[k-1];
            assign v  = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v;
            end
            if (i_en) begin
                if (za >= 0) begin
                    r_xa[k] <= xa - (ya >>> k);
                    r_ya[k] <= ya + (xa >>> k);
                    r_za[k] <= za - atan_q29(k);
                end else begin
                    r_xa[k] <= xa + (ya >>> k);
                    r_ya[k] <= ya - (xa >>> k);
                    r_za[k] <= za + atan_q29(k);
                end
                if (zb >= 0) begin
                    r_xb[k] <= xb - (yb >>> k);
                    r_yb[k] <= yb + (xb >>> k);
                    r_zb[k] <= zb - atan_q29(k);
                end else begin
                    r_xb[k] <= xb + (yb >>> k);
                    r_yb[k] <= yb - (xb >>> k);
                    r_zb[k] <= zb + atan_q29(k);
                end
                r_fa[k]  <= fa;
                r_fb[k]  <= fb;
                r_geo[k] <= g;
            end
        end
    end

    assign o_valid  = r_vld[N-1];
    assign o_ca     = r_xa[N-1];
    assign o_sa     = r_ya[N-1];
    assign o_cb     = r_xb[N-1];
    assign o_sb     = r_yb[N-1];
    assign o_flip_a = r_fa[N-1];
    assign o_flip_b = r_fb[N-1];
    assign o_geo    = r_geo[N-1];

endmodule

>>> rtl/hap_div.sv
// hap_div: multi-lane unsigned restoring divider, one quotient bit per stage
// self-contained; a sideband word travels alongside each item
module hap_div #(
    parameter int LANES = 3,
    parameter int NW    = 63,
    parameter int DW    = 25,
    parameter int SW    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NW-1:0]      i_num,
    input  logic [LANES-1:0][DW-1:0]      i_den,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][NW-1:0]      o_quo,
    output logic [SW-1:0]                 o_side
);

    logic [LANES-1:0][NW-1:0] r_q    [NW];
    logic [LANES-1:0][DW-1:0] r_rem  [NW];
    logic [LANES-1:0][DW-1:0] r_den  [NW];
    logic [SW-1:0]            r_side [NW];
    logic                     r_vld  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [LANES-1:0][NW-1:0] q;
        logic [LANES-1:0][DW-1:0] rem, den;
        logic [SW-1:0]            side;
        logic                     v;
        logic [LANES-1:0][DW:0]   trial;
        logic [LANES-1:0][NW-1:0] n_q;
        logic [LANES-1:0][DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign q    = i_num;
            assign rem  = '0;
            assign den  = i_den;
            assign side = i_side;
            assign v    = i_valid;
        end else begin : g_next
            assign q    = r_q[k-1];
            assign rem  = r_rem[k-1];
            assign den  = r_den[k-1];
            assign side = r_side[k-1];
            assign v    = r_vld[k-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {rem[l], q[l][NW-1]};
                if (trial[l] >= {1'b0, den[l]}) begin
                    n_rem[l] = DW'(trial[l] - {1'b0, den[l]});
                    n_q[l]   = {q[l][NW-2:0], 1'b1};
                end else begin
                    n_rem[l] = trial[l][DW-1:0];
                    n_q[l]   = {q[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v;
            end
            if (i_en) begin
                r_q[k]    <= n_q;
                r_rem[k]  <= n_rem;
                r_den[k]  <= den;
                r_side[k] <= side;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_q[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

>>> rtl/hap_pen.sv
// hap_pen: three-lane excess, weighting and saturation, three register stages
// depends on hap_pkg for the quotient width and excess cap
module hap_pen (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_fault,
    input  logic [2:0][hap_pkg::DIV2_NW-1:0]    i_mag,
    input  logic [2:0][31:0]                    i_limit,
    input  logic [15:0]                         i_margin,
    input  logic [2:0][23:0]                    i_weight,
    output logic                                o_valid,
    output logic                                o_fault,
    output logic [2:0][31:0]                    o_pen
);
    import hap_pkg::*;

    logic [2:0][39:0] n_ex, r_ex;
    logic [2:0][63:0] r_prod;
    logic [2:0][31:0] n_pen, r_pen;
    logic [2:0][32:0] band;
    logic [2:0][DIV2_NW-1:0] diff;
    logic [2:0] r_vld;
    logic [2:0] r_flt;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            band[l] = {1'b0, i_limit[l]} - {17'b0, i_margin};
            if (band[l][32]) begin
                band[l] = '0;
            end
            diff[l] = '0;
            if (i_mag[l] > DIV2_NW'(band[l])) begin
                diff[l] = i_mag[l] - DIV2_NW'(band[l]);
            end
            if (diff[l] > DIV2_NW'(EXCESS_CAP)) begin
                n_ex[l] = EXCESS_CAP;
            end else begin
                n_ex[l] = diff[l][39:0];
            end
            if (r_flt[1] || (r_prod[l][63:48] != 16'b0)) begin
                n_pen[l] = '1;
            end else begin
                n_pen[l] = r_prod[l][47:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        if (i_en) begin
            r_flt <= {r_flt[1:0], i_fault};
            r_ex  <= n_ex;
            for (int l = 0; l < 3; l++) begin
                r_prod[l] <= 64'(r_ex[l]) * 64'(i_weight[l]);
            end
            r_pen <= n_pen;
        end
    end

    assign o_valid = r_vld[2];
    assign o_fault = r_flt[2];
    assign o_pen   = r_pen;

endmodule
